// ===== rtl/quat_scale_translate_point_defines.svh =====
// Assertion macros for the quaternion scale/rotate/translate block.
`ifndef QUAT_SCALE_TRANSLATE_POINT_DEFINES_SVH
`define QUAT_SCALE_TRANSLATE_POINT_DEFINES_SVH

// Same-cycle implication.
`define QSTP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qstp: implication check failed");

// Implication after a fixed number of cycles.
`define QSTP_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
      else $error("qstp: delayed check failed");

`endif

// ===== rtl/qstp_pkg.sv =====
// Shared types, codes and width helpers for the quaternion transform pipeline.
package qstp_pkg;

   localparam logic [2:0] CMD_FULL       = 3'd0;
   localparam logic [2:0] CMD_SCALED_VEC = 3'd1;
   localparam logic [2:0] CMD_POINT      = 3'd2;
   localparam logic [2:0] CMD_VEC        = 3'd3;
   localparam logic [2:0] CMD_INV_POINT  = 3'd4;

   localparam logic [2:0] REG_QUAT  = 3'd0;
   localparam logic [2:0] REG_OFF_X = 3'd1;
   localparam logic [2:0] REG_OFF_Y = 3'd2;
   localparam logic [2:0] REG_OFF_Z = 3'd3;
   localparam logic [2:0] REG_SCL_X = 3'd4;
   localparam logic [2:0] REG_SCL_Y = 3'd5;
   localparam logic [2:0] REG_SCL_Z = 3'd6;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam int PIPE_LAT = 7;

   localparam int VEC_W   = 33;
   localparam int QUAT_W  = 17;
   localparam int PROD_W  = QUAT_W + VEC_W;
   localparam int CROSS_W = PROD_W + 1;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   function automatic int t_width(input int frac);
      return CROSS_W + 3 - frac;
   endfunction

   function automatic int sum_width(input int frac);
      return QUAT_W + t_width(frac) + 2;
   endfunction

   function automatic int rot_width(input int frac);
      return sum_width(frac) + 2;
   endfunction

   typedef struct packed {
      logic [63:0]      quat;
      logic [2:0][31:0] off;
      logic [2:0][31:0] scl;
   } qstp_cfg_type;

   typedef struct packed {
      logic valid;
      logic scale;
      logic inverse;
      logic add_off;
      logic zero;
      logic ovf;
   } qstp_ctl_type;

endpackage

// ===== rtl/quat_scale_translate_point.sv =====
// Top level: scale, quaternion rotate and translate one Q16.16 point per item.
// Throughput: one item per cycle; busy is low except during reset, results cannot stall.
// Seven register stages: scale multiply, operand select, two multiply/round pairs, output.
// Reset is synchronous: it empties the pipeline and loads the default transform.
`include "quat_scale_translate_point_defines.svh"

module quat_scale_translate_point #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int QUAT_FRAC_BITS  = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [2:0]                        req_cmd,
   input  logic signed [31:0]                req_vec_x,
   input  logic signed [31:0]                req_vec_y,
   input  logic signed [31:0]                req_vec_z,
   output logic                              rsp_valid,
   output logic signed [31:0]                rsp_out_x,
   output logic signed [31:0]                rsp_out_y,
   output logic signed [31:0]                rsp_out_z,
   output logic                              rsp_overflow,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [qstp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [qstp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [qstp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import qstp_pkg::*;

   localparam int RW = rot_width(QUAT_FRAC_BITS);

   qstp_cfg_type             cfg;
   qstp_ctl_type             scl_ctl;
   qstp_ctl_type             rot_ctl;
   logic signed [31:0]       vec_in [3];
   logic signed [VEC_W-1:0]  scl_vec [3];
   logic signed [QUAT_W-1:0] scl_quat [4];
   logic signed [RW-1:0]     rot [3];

   logic                     valid_ff, valid_in;
   logic signed [31:0]       out_ff [3];
   logic signed [31:0]       out_in [3];
   logic                     ovf_ff, ovf_in;

   logic                     unused_acc;
   logic                     rsp_zero;

   assign busy      = reset;
   assign vec_in[0] = req_vec_x;
   assign vec_in[1] = req_vec_y;
   assign vec_in[2] = req_vec_z;

   qstp_csr #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS),
      .QUAT_FRAC_BITS  (QUAT_FRAC_BITS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   qstp_scale #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_scale (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .cmd      (req_cmd),
      .vec_i    (vec_in),
      .cfg      (cfg),
      .ctl_o    (scl_ctl),
      .vec_o    (scl_vec),
      .quat_o   (scl_quat)
   );

   qstp_rotate #(
      .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
   ) u_rotate (
      .clock  (clock),
      .reset  (reset),
      .ctl_i  (scl_ctl),
      .vec_i  (scl_vec),
      .quat_i (scl_quat),
      .ctl_o  (rot_ctl),
      .rot_o  (rot)
   );

   always_comb begin
      logic signed [RW:0] sum;
      logic               sat_any;
      sat_any = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (rot_ctl.add_off) begin
            sum = (RW + 1)'(rot[i]) + (RW + 1)'($signed(cfg.off[i]));
         end else begin
            sum = (RW + 1)'(rot[i]);
         end
         if (sum > S32_MAX) begin
            out_in[i] = S32_MAX;
            sat_any   = 1'b1;
         end else if (sum < S32_MIN) begin
            out_in[i] = S32_MIN;
            sat_any   = 1'b1;
         end else begin
            out_in[i] = 32'(sum);
         end
      end
      ovf_in = rot_ctl.ovf || sat_any;
      if (rot_ctl.zero) begin
         for (int i = 0; i < 3; i++) begin
            out_in[i] = 32'sd0;
         end
         ovf_in = 1'b0;
      end
      valid_in = rot_ctl.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      ovf_ff <= ovf_in;
      for (int i = 0; i < 3; i++) begin
         out_ff[i] <= out_in[i];
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_x    = out_ff[0];
   assign rsp_out_y    = out_ff[1];
   assign rsp_out_z    = out_ff[2];
   assign rsp_overflow = ovf_ff;

   assign unused_acc = start && !busy && (req_cmd > CMD_INV_POINT);
   assign rsp_zero   = rsp_valid && !rsp_overflow && (rsp_out_x == 32'sd0)
                       && (rsp_out_y == 32'sd0) && (rsp_out_z == 32'sd0);

   `QSTP_ASSERT_DELAY(a_item_latency, clock, reset, start && !busy, PIPE_LAT, rsp_valid)
   `QSTP_ASSERT_IMPL(a_no_spurious, clock, reset, rsp_valid, $past(start && !busy, PIPE_LAT))
   `QSTP_ASSERT_DELAY(a_unused_cmd, clock, reset, unused_acc, PIPE_LAT, rsp_zero)

endmodule

// ===== rtl/qstp_csr.sv =====
// APB register file holding quaternion, translation and scale.
module qstp_csr #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int QUAT_FRAC_BITS  = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [qstp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [qstp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [qstp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output qstp_pkg::qstp_cfg_type            cfg
);
   import qstp_pkg::*;

   logic [63:0]      quat_ff, quat_in;
   logic [2:0][31:0] off_ff, off_in;
   logic [2:0][31:0] scl_ff, scl_in;
   logic [2:0]       idx;
   logic             wr;

   assign idx    = paddr[5:3];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      quat_in = quat_ff;
      off_in  = off_ff;
      scl_in  = scl_ff;
      if (wr) begin
         case (idx)
            REG_QUAT:  quat_in   = pwdata;
            REG_OFF_X: off_in[0] = pwdata[31:0];
            REG_OFF_Y: off_in[1] = pwdata[31:0];
            REG_OFF_Z: off_in[2] = pwdata[31:0];
            REG_SCL_X: scl_in[0] = pwdata[31:0];
            REG_SCL_Y: scl_in[1] = pwdata[31:0];
            REG_SCL_Z: scl_in[2] = pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff <= 64'(1) << (48 + QUAT_FRAC_BITS);
         for (int i = 0; i < 3; i++) begin
            off_ff[i] <= 32'd0;
            scl_ff[i] <= 32'(1) << COORD_FRAC_BITS;
         end
      end else begin
         quat_ff <= quat_in;
         off_ff  <= off_in;
         scl_ff  <= scl_in;
      end
   end

   always_comb begin
      case (idx)
         REG_QUAT:  prdata = quat_ff;
         REG_OFF_X: prdata = {32'd0, off_ff[0]};
         REG_OFF_Y: prdata = {32'd0, off_ff[1]};
         REG_OFF_Z: prdata = {32'd0, off_ff[2]};
         REG_SCL_X: prdata = {32'd0, scl_ff[0]};
         REG_SCL_Y: prdata = {32'd0, scl_ff[1]};
         REG_SCL_Z: prdata = {32'd0, scl_ff[2]};
         default:   prdata = '0;
      endcase
   end

   assign cfg.quat = quat_ff;
   assign cfg.off  = off_ff;
   assign cfg.scl  = scl_ff;

endmodule

// ===== rtl/qstp_scale.sv =====
// Front stages: per-axis scale multiply, saturation and rotation operand select.
module qstp_scale #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic [2:0]                            cmd,
   input  logic signed [31:0]                    vec_i [3],
   input  qstp_pkg::qstp_cfg_type                cfg,
   output qstp_pkg::qstp_ctl_type                ctl_o,
   output logic signed [qstp_pkg::VEC_W-1:0]     vec_o [3],
   output logic signed [qstp_pkg::QUAT_W-1:0]    quat_o [4]
);
   import qstp_pkg::*;

   localparam logic signed [63:0] SCL_HALF = 64'sd1 <<< (COORD_FRAC_BITS - 1);

   // stage 1
   qstp_ctl_type      ctl1_ff, ctl1_in;
   logic signed [63:0] prod_ff [3];
   logic signed [63:0] prod_in [3];
   logic signed [31:0] vec1_ff [3];

   // stage 2
   qstp_ctl_type              ctl2_ff, ctl2_in;
   logic signed [VEC_W-1:0]   vec2_ff [3];
   logic signed [VEC_W-1:0]   vec2_in [3];
   logic signed [QUAT_W-1:0]  quat2_ff [4];
   logic signed [QUAT_W-1:0]  quat2_in [4];

   always_comb begin
      ctl1_in.valid   = in_valid;
      ctl1_in.scale   = (cmd == CMD_FULL) || (cmd == CMD_SCALED_VEC);
      ctl1_in.inverse = (cmd == CMD_INV_POINT);
      ctl1_in.add_off = (cmd == CMD_FULL) || (cmd == CMD_POINT);
      ctl1_in.zero    = (cmd > CMD_INV_POINT);
      ctl1_in.ovf     = 1'b0;
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = vec_i[i] * $signed(cfg.scl[i]);
      end
   end

   always_comb begin
      logic signed [63:0] rnd;
      logic               sat_any;
      sat_any = 1'b0;
      for (int i = 0; i < 3; i++) begin
         rnd = (prod_ff[i] + SCL_HALF) >>> COORD_FRAC_BITS;
         if (ctl1_ff.scale) begin
            if (rnd > S32_MAX) begin
               vec2_in[i] = VEC_W'(S32_MAX);
               sat_any    = 1'b1;
            end else if (rnd < S32_MIN) begin
               vec2_in[i] = VEC_W'(S32_MIN);
               sat_any    = 1'b1;
            end else begin
               vec2_in[i] = VEC_W'(rnd);
            end
         end else if (ctl1_ff.inverse) begin
            vec2_in[i] = VEC_W'(vec1_ff[i]) - VEC_W'($signed(cfg.off[i]));
         end else begin
            vec2_in[i] = VEC_W'(vec1_ff[i]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (ctl1_ff.inverse) begin
            quat2_in[i] = -QUAT_W'($signed(cfg.quat[16*i +: 16]));
         end else begin
            quat2_in[i] = QUAT_W'($signed(cfg.quat[16*i +: 16]));
         end
      end
      quat2_in[3] = QUAT_W'($signed(cfg.quat[63:48]));
      ctl2_in     = ctl1_ff;
      ctl2_in.ovf = ctl1_ff.scale && sat_any;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
      end else begin
         ctl1_ff.valid <= ctl1_in.valid;
         ctl2_ff.valid <= ctl2_in.valid;
      end
      ctl1_ff.scale   <= ctl1_in.scale;
      ctl1_ff.inverse <= ctl1_in.inverse;
      ctl1_ff.add_off <= ctl1_in.add_off;
      ctl1_ff.zero    <= ctl1_in.zero;
      ctl1_ff.ovf     <= ctl1_in.ovf;
      ctl2_ff.scale   <= ctl2_in.scale;
      ctl2_ff.inverse <= ctl2_in.inverse;
      ctl2_ff.add_off <= ctl2_in.add_off;
      ctl2_ff.zero    <= ctl2_in.zero;
      ctl2_ff.ovf     <= ctl2_in.ovf;
      for (int i = 0; i < 3; i++) begin
         prod_ff[i] <= prod_in[i];
         vec1_ff[i] <= vec_i[i];
         vec2_ff[i] <= vec2_in[i];
      end
      for (int i = 0; i < 4; i++) begin
         quat2_ff[i] <= quat2_in[i];
      end
   end

   assign ctl_o = ctl2_ff;
   assign vec_o = vec2_ff;
   assign quat_o = quat2_ff;

endmodule

// ===== rtl/qstp_rotate.sv =====
// Four-stage quaternion rotation: v + w*t + q x t with t = 2 (q x v).
module qstp_rotate #(
   parameter int QUAT_FRAC_BITS = 14
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  qstp_pkg::qstp_ctl_type                                ctl_i,
   input  logic signed [qstp_pkg::VEC_W-1:0]                     vec_i [3],
   input  logic signed [qstp_pkg::QUAT_W-1:0]                    quat_i [4],
   output qstp_pkg::qstp_ctl_type                                ctl_o,
   output logic signed [qstp_pkg::rot_width(QUAT_FRAC_BITS)-1:0] rot_o [3]
);
   import qstp_pkg::*;

   localparam int TW = t_width(QUAT_FRAC_BITS);
   localparam int UW = QUAT_W + TW;
   localparam int SW = sum_width(QUAT_FRAC_BITS);
   localparam int RW = rot_width(QUAT_FRAC_BITS);
   localparam logic signed [CROSS_W:0] T_HALF = (CROSS_W + 1)'(1) <<< (QUAT_FRAC_BITS - 2);
   localparam logic signed [SW:0]      S_HALF = (SW + 1)'(1) <<< (QUAT_FRAC_BITS - 1);

   qstp_ctl_type ctl3_ff, ctl4_ff, ctl5_ff, ctl6_ff;

   // stage 3: first cross product terms
   logic signed [PROD_W-1:0] hi3_ff [3];
   logic signed [PROD_W-1:0] hi3_in [3];
   logic signed [PROD_W-1:0] lo3_ff [3];
   logic signed [PROD_W-1:0] lo3_in [3];
   logic signed [VEC_W-1:0]  vec3_ff [3];
   logic signed [QUAT_W-1:0] quat3_ff [4];

   // stage 4: t = 2 (q x v), rounded
   logic signed [TW-1:0]     t4_ff [3];
   logic signed [TW-1:0]     t4_in [3];
   logic signed [VEC_W-1:0]  vec4_ff [3];
   logic signed [QUAT_W-1:0] quat4_ff [4];

   // stage 5: w*t and q x t terms
   logic signed [UW-1:0]    wt5_ff [3];
   logic signed [UW-1:0]    wt5_in [3];
   logic signed [UW-1:0]    hi5_ff [3];
   logic signed [UW-1:0]    hi5_in [3];
   logic signed [UW-1:0]    lo5_ff [3];
   logic signed [UW-1:0]    lo5_in [3];
   logic signed [VEC_W-1:0] vec5_ff [3];

   // stage 6: rounded sum plus v
   logic signed [RW-1:0] rot6_ff [3];
   logic signed [RW-1:0] rot6_in [3];

   for (genvar g = 0; g < 3; g++) begin : g_axis
      localparam int J = (g + 1) % 3;
      localparam int K = (g + 2) % 3;
      logic signed [CROSS_W-1:0] cross_v;
      logic signed [CROSS_W:0]   cross_rnd;
      logic signed [SW-1:0]      sum;
      logic signed [SW:0]        sum_rnd;

      assign hi3_in[g] = quat_i[J] * vec_i[K];
      assign lo3_in[g] = quat_i[K] * vec_i[J];

      assign cross_v   = CROSS_W'(hi3_ff[g]) - CROSS_W'(lo3_ff[g]);
      assign cross_rnd = (CROSS_W + 1)'(cross_v) + T_HALF;
      assign t4_in[g]  = TW'(cross_rnd >>> (QUAT_FRAC_BITS - 1));

      assign wt5_in[g] = quat4_ff[3] * t4_ff[g];
      assign hi5_in[g] = quat4_ff[J] * t4_ff[K];
      assign lo5_in[g] = quat4_ff[K] * t4_ff[J];

      assign sum        = SW'(wt5_ff[g]) + SW'(hi5_ff[g]) - SW'(lo5_ff[g]);
      assign sum_rnd    = (SW + 1)'(sum) + S_HALF;
      assign rot6_in[g] = RW'(vec5_ff[g]) + RW'(sum_rnd >>> QUAT_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff.valid <= 1'b0;
         ctl4_ff.valid <= 1'b0;
         ctl5_ff.valid <= 1'b0;
         ctl6_ff.valid <= 1'b0;
      end else begin
         ctl3_ff.valid <= ctl_i.valid;
         ctl4_ff.valid <= ctl3_ff.valid;
         ctl5_ff.valid <= ctl4_ff.valid;
         ctl6_ff.valid <= ctl5_ff.valid;
      end
      ctl3_ff.scale   <= ctl_i.scale;
      ctl3_ff.inverse <= ctl_i.inverse;
      ctl3_ff.add_off <= ctl_i.add_off;
      ctl3_ff.zero    <= ctl_i.zero;
      ctl3_ff.ovf     <= ctl_i.ovf;
      ctl4_ff.scale   <= ctl3_ff.scale;
      ctl4_ff.inverse <= ctl3_ff.inverse;
      ctl4_ff.add_off <= ctl3_ff.add_off;
      ctl4_ff.zero    <= ctl3_ff.zero;
      ctl4_ff.ovf     <= ctl3_ff.ovf;
      ctl5_ff.scale   <= ctl4_ff.scale;
      ctl5_ff.inverse <= ctl4_ff.inverse;
      ctl5_ff.add_off <= ctl4_ff.add_off;
      ctl5_ff.zero    <= ctl4_ff.zero;
      ctl5_ff.ovf     <= ctl4_ff.ovf;
      ctl6_ff.scale   <= ctl5_ff.scale;
      ctl6_ff.inverse <= ctl5_ff.inverse;
      ctl6_ff.add_off <= ctl5_ff.add_off;
      ctl6_ff.zero    <= ctl5_ff.zero;
      ctl6_ff.ovf     <= ctl5_ff.ovf;
      for (int i = 0; i < 3; i++) begin
         hi3_ff[i]  <= hi3_in[i];
         lo3_ff[i]  <= lo3_in[i];
         vec3_ff[i] <= vec_i[i];
         t4_ff[i]   <= t4_in[i];
         vec4_ff[i] <= vec3_ff[i];
         wt5_ff[i]  <= wt5_in[i];
         hi5_ff[i]  <= hi5_in[i];
         lo5_ff[i]  <= lo5_in[i];
         vec5_ff[i] <= vec4_ff[i];
         rot6_ff[i] <= rot6_in[i];
      end
      for (int i = 0; i < 4; i++) begin
         quat3_ff[i] <= quat_i[i];
         quat4_ff[i] <= quat3_ff[i];
      end
   end

   assign ctl_o = ctl6_ff;
   assign rot_o = rot6_ff;

endmodule

// ===== test/quat_scale_translate_point_tb.sv =====
// Testbench for quat_scale_translate_point: directed table and random items checked against a predictor.
module quat_scale_translate_point_tb;
   import qstp_pkg::*;

   localparam int COORD_FRAC = 16;
   localparam int QUAT_FRAC = 14;
   localparam logic [2:0] CMD_RSVD_5 = 3'd5;
   localparam logic [2:0] CMD_RSVD_6 = 3'd6;
   localparam logic [2:0] CMD_RSVD_7 = 3'd7;
   localparam logic [2:0] REG_NONE = 3'd7;
   localparam logic signed [31:0] ONE = 32'sh0001_0000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 200;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [2:0][31:0] p;
      logic ovf;
   } point_type;

   typedef enum {EXP_PREDICT, EXP_IDENTITY, EXP_ZERO} exp_kind_type;
   typedef enum {CFG_KEEP, CFG_NEG_FULL, CFG_POS_FULL, CFG_QUARTER_TURN} dir_cfg_type;

   typedef struct {
      dir_cfg_type setup;
      logic [2:0] cmd;
      logic [2:0][31:0] v;
      exp_kind_type kind;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [2:0] req_cmd;
   logic signed [31:0] req_vec_x;
   logic signed [31:0] req_vec_y;
   logic signed [31:0] req_vec_z;
   logic rsp_valid;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;
   logic rsp_overflow;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   qstp_cfg_type model_cfg;
   point_type pending_points[$];
   stim_row_type dir_rows[$];
   logic [2:0] op_codes[8];
   bit no_gaps = 1'b0;
   int fails = 0;
   int unsigned cycles = 0;

   quat_scale_translate_point dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_vec_x(req_vec_x),
      .req_vec_y(req_vec_y),
      .req_vec_z(req_vec_z),
      .rsp_valid(rsp_valid),
      .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z),
      .rsp_overflow(rsp_overflow),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic longint round_half_up(input longint a, input int k);
      return (a + (longint'(1) << (k - 1))) >>> k;
   endfunction

   function automatic longint clamp32(input longint a, inout bit ovf);
      if (a > longint'(S32_MAX)) begin
         ovf = 1'b1;
         return longint'(S32_MAX);
      end
      if (a < longint'(S32_MIN)) begin
         ovf = 1'b1;
         return longint'(S32_MIN);
      end
      return a;
   endfunction

   // scale, rotate by v + w*t + q x t with t = 2(q x v), translate
   function automatic point_type transform_point(input logic [2:0] cmd,
                                                 input logic [2:0][31:0] vin);
      longint q[4];
      longint v[3];
      longint off[3];
      longint c[3];
      longint t[3];
      longint u[3];
      longint r[3];
      bit ovf;
      point_type res;
      int i;
      ovf = 1'b0;
      for (i = 0; i < 4; i++)
         q[i] = longint'($signed(model_cfg.quat[16*i +: 16]));
      for (i = 0; i < 3; i++) begin
         v[i] = longint'($signed(vin[i]));
         off[i] = longint'($signed(model_cfg.off[i]));
         r[i] = 0;
      end
      if (cmd == CMD_FULL || cmd == CMD_SCALED_VEC || cmd == CMD_POINT ||
          cmd == CMD_VEC || cmd == CMD_INV_POINT) begin
         if (cmd == CMD_FULL || cmd == CMD_SCALED_VEC) begin
            for (i = 0; i < 3; i++)
               v[i] = clamp32(round_half_up(v[i] * longint'($signed(model_cfg.scl[i])),
                                            COORD_FRAC), ovf);
         end
         if (cmd == CMD_INV_POINT) begin
            for (i = 0; i < 3; i++) begin
               v[i] -= off[i];
               q[i] = -q[i];
            end
         end
         c[0] = q[1] * v[2] - q[2] * v[1];
         c[1] = q[2] * v[0] - q[0] * v[2];
         c[2] = q[0] * v[1] - q[1] * v[0];
         for (i = 0; i < 3; i++)
            t[i] = round_half_up(c[i], QUAT_FRAC - 1);
         u[0] = q[1] * t[2] - q[2] * t[1];
         u[1] = q[2] * t[0] - q[0] * t[2];
         u[2] = q[0] * t[1] - q[1] * t[0];
         for (i = 0; i < 3; i++) begin
            r[i] = v[i] + round_half_up(q[3] * t[i] + u[i], QUAT_FRAC);
            if (cmd == CMD_FULL || cmd == CMD_POINT)
               r[i] += off[i];
            r[i] = clamp32(r[i], ovf);
         end
      end
      for (i = 0; i < 3; i++)
         res.p[i] = r[i][31:0];
      res.ovf = ovf;
      return res;
   endfunction

   function automatic logic [31:0] random_coord();
      int unsigned k;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return S32_MAX;
               1: return S32_MIN;
               2: return 32'd0;
               3: return -32'sd1;
               default: return 32'd1;
            endcase
         end
         1, 2, 3: return $urandom;
         default: begin
            k = $urandom_range(8, 25);
            return $urandom_range(0, (1 << k) - 1) - (1 << (k - 1));
         end
      endcase
   endfunction

   function automatic logic [2:0] random_cmd();
      int unsigned r;
      r = $urandom_range(0, 99);
      return (r < 90) ? op_codes[r % 5] : op_codes[5 + r % 3];
   endfunction

   function automatic logic [63:0] random_unit_quat();
      real ax;
      real ay;
      real az;
      real len;
      real half;
      real s;
      logic [15:0] qx;
      logic [15:0] qy;
      logic [15:0] qz;
      logic [15:0] qw;
      ax = real'($urandom_range(0, 2000)) - 1000.0;
      ay = real'($urandom_range(0, 2000)) - 1000.0;
      az = real'($urandom_range(0, 2000)) - 1000.0;
      len = $sqrt(ax * ax + ay * ay + az * az);
      if (len < 1.0) begin
         ax = 1.0;
         len = 1.0;
      end
      half = real'($urandom_range(0, 31416)) / 10000.0;
      s = $sin(half) * 16384.0 / len;
      qx = 16'(int'(ax * s));
      qy = 16'(int'(ay * s));
      qz = 16'(int'(az * s));
      qw = 16'(int'($cos(half) * 16384.0));
      return {qw, qz, qy, qx};
   endfunction

   function automatic void add_row(input dir_cfg_type setup, input logic [2:0] cmd,
                                   input logic [31:0] x, input logic [31:0] y,
                                   input logic [31:0] z, input exp_kind_type kind);
      stim_row_type row;
      row.setup = setup;
      row.cmd = cmd;
      row.v = {z, y, x};
      row.kind = kind;
      dir_rows.push_back(row);
   endfunction

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (pending_points.size() != 0);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'({idx, 3'b000});
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_QUAT: model_cfg.quat = val;
         REG_OFF_X, REG_OFF_Y, REG_OFF_Z:
            model_cfg.off[2'(idx - REG_OFF_X)] = val[31:0];
         REG_SCL_X, REG_SCL_Y, REG_SCL_Z:
            model_cfg.scl[2'(idx - REG_SCL_X)] = val[31:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_transform(input logic [63:0] quat, input logic [2:0][63:0] off,
                                 input logic [2:0][63:0] scl);
      int i;
      wait_idle();
      csr_write(REG_QUAT, quat);
      for (i = 0; i < 3; i++) begin
         csr_write(3'(REG_OFF_X + i), off[i]);
         csr_write(3'(REG_SCL_X + i), scl[i]);
      end
      // unmapped index, must be ignored
      csr_write(REG_NONE, {$urandom, $urandom});
   endtask

   task automatic load_random_transform(input int p);
      logic [2:0][63:0] off;
      logic [2:0][63:0] scl;
      logic [63:0] quat;
      int unsigned mag;
      int i;
      quat = random_unit_quat();
      for (i = 0; i < 3; i++) begin
         if (p % 2 == 0) begin
            off[i] = {32'd0, 32'($urandom_range(0, 1 << 25) - (1 << 24))};
            mag = $urandom_range(16384, 262144);
            scl[i] = {32'd0, $urandom_range(0, 1) ? 32'(-mag) : 32'(mag)};
         end else if (p % 4 == 1) begin
            quat = {$urandom, $urandom};
            off[i] = {$urandom, $urandom};
            scl[i] = {$urandom, $urandom};
         end else begin
            off[i] = {32'd0, $urandom_range(0, 1) ? S32_MIN : S32_MAX};
            case ($urandom_range(0, 3))
               0: scl[i] = 64'd0;
               1: scl[i] = {32'd0, S32_MIN};
               2: scl[i] = {32'd0, S32_MAX};
               default: scl[i] = {32'd0, -ONE};
            endcase
         end
      end
      load_transform(quat, off, scl);
   endtask

   task automatic send_item(input logic [2:0] cmd, input logic [2:0][31:0] v,
                            input point_type want);
      req_cmd <= cmd;
      req_vec_x <= v[0];
      req_vec_y <= v[1];
      req_vec_z <= v[2];
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_points.push_back(want);
      if (!no_gaps && $urandom_range(0, 99) < 24) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin : result_check
      point_type got;
      point_type want;
      int i;
      got.p = {rsp_out_z, rsp_out_y, rsp_out_x};
      got.ovf = rsp_overflow;
      if (!reset && rsp_valid) begin
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected item x=%0d y=%0d z=%0d overflow=%0b", $time,
                     rsp_out_x, rsp_out_y, rsp_out_z, rsp_overflow);
            fails++;
         end else begin
            want = pending_points.pop_front();
            for (i = 0; i < 3; i++) begin
               if (got.p[i] !== want.p[i]) begin
                  $display("%0t: axis %0d expected %0d got %0d", $time, i,
                           $signed(want.p[i]), $signed(got.p[i]));
                  fails++;
               end
            end
            if (got.ovf !== want.ovf) begin
               $display("%0t: overflow expected %0b got %0b", $time, want.ovf, got.ovf);
               fails++;
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      logic [2:0][31:0] v;
      logic [2:0] cmd;
      point_type want;
      int p;
      int n;
      reset <= 1'b1;
      start <= 1'b0;
      req_cmd <= CMD_FULL;
      req_vec_x <= '0;
      req_vec_y <= '0;
      req_vec_z <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      op_codes = '{CMD_FULL, CMD_SCALED_VEC, CMD_POINT, CMD_VEC, CMD_INV_POINT,
                   CMD_RSVD_5, CMD_RSVD_6, CMD_RSVD_7};
      model_cfg.quat = 64'h4000_0000_0000_0000;
      model_cfg.off = '0;
      model_cfg.scl = {ONE, ONE, ONE};

      // reset transform is the identity
      add_row(CFG_KEEP, CMD_FULL, 32'd0, 32'd0, 32'd0, EXP_IDENTITY);
      add_row(CFG_KEEP, CMD_FULL, S32_MAX, S32_MIN, ONE, EXP_IDENTITY);
      add_row(CFG_KEEP, CMD_SCALED_VEC, S32_MIN, S32_MAX, -32'sd1, EXP_IDENTITY);
      add_row(CFG_KEEP, CMD_POINT, 32'h1234_5678, 32'hF543_2110, ONE, EXP_IDENTITY);
      add_row(CFG_KEEP, CMD_VEC, S32_MAX, S32_MAX, S32_MAX, EXP_IDENTITY);
      add_row(CFG_KEEP, CMD_INV_POINT, S32_MIN, S32_MIN, S32_MIN, EXP_IDENTITY);
      add_row(CFG_KEEP, CMD_RSVD_5, S32_MAX, S32_MIN, ONE, EXP_ZERO);
      add_row(CFG_KEEP, CMD_RSVD_6, S32_MIN, ONE, S32_MAX, EXP_ZERO);
      add_row(CFG_KEEP, CMD_RSVD_7, -32'sd1, -32'sd1, -32'sd1, EXP_ZERO);
      // quaternion parts at -32768, saturating scale and offset
      add_row(CFG_NEG_FULL, CMD_FULL, S32_MAX, S32_MIN, ONE, EXP_PREDICT);
      add_row(CFG_KEEP, CMD_SCALED_VEC, ONE, -ONE, 32'd0, EXP_PREDICT);
      add_row(CFG_KEEP, CMD_POINT, ONE, ONE, ONE, EXP_PREDICT);
      add_row(CFG_KEEP, CMD_VEC, 32'd1, -32'sd1, 32'd0, EXP_PREDICT);
      add_row(CFG_KEEP, CMD_INV_POINT, S32_MIN, S32_MIN, S32_MIN, EXP_PREDICT);
      add_row(CFG_KEEP, CMD_RSVD_7, ONE, ONE, ONE, EXP_ZERO);
      // non-unit quaternion at the positive limit
      add_row(CFG_POS_FULL, CMD_FULL, S32_MIN, S32_MIN, S32_MIN, EXP_PREDICT);
      add_row(CFG_KEEP, CMD_SCALED_VEC, 32'd1, 32'd1, 32'd1, EXP_PREDICT);
      add_row(CFG_KEEP, CMD_POINT, 32'd0, 32'd0, 32'd0, EXP_PREDICT);
      add_row(CFG_KEEP, CMD_VEC, S32_MAX, 32'd0, S32_MIN, EXP_PREDICT);
      add_row(CFG_KEEP, CMD_INV_POINT, S32_MAX, S32_MAX, S32_MAX, EXP_PREDICT);
      // quarter turn about z, scale 2, offset (1,2,3)
      add_row(CFG_QUARTER_TURN, CMD_FULL, ONE, 32'd0, 32'd0, EXP_PREDICT);
      add_row(CFG_KEEP, CMD_INV_POINT, ONE, 32'h0003_0000, -ONE, EXP_PREDICT);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < dir_rows.size(); n++) begin
         row = dir_rows[n];
         case (row.setup)
            CFG_NEG_FULL:
               load_transform(64'h8000_8000_8000_8000, {3{64'(S32_MAX)}},
                              {3{64'(S32_MAX)}});
            CFG_POS_FULL:
               load_transform(64'h7FFF_7FFF_7FFF_7FFF, {3{64'(S32_MIN)}},
                              {3{64'(S32_MIN)}});
            CFG_QUARTER_TURN:
               load_transform({16'd11585, 16'd11585, 32'd0},
                              {64'h3_0000, 64'h2_0000, 64'h1_0000},
                              {3{64'h2_0000}});
            default: ;
         endcase
         case (row.kind)
            EXP_IDENTITY: want = {row.v, 1'b0};
            EXP_ZERO: want = '0;
            default: want = transform_point(row.cmd, row.v);
         endcase
         send_item(row.cmd, row.v, want);
      end

      for (p = 0; p < RANDOM_PHASES; p++) begin
         load_random_transform(p);
         no_gaps = (p == 2);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 4 && n == PHASE_ITEMS / 2)
               wait_idle();
            cmd = random_cmd();
            v = {random_coord(), random_coord(), random_coord()};
            send_item(cmd, v, transform_point(cmd, v));
         end
      end
      no_gaps = 1'b0;

      wait_idle();
      repeat (PIPE_LAT + 4) @(posedge clock);
      if (fails == 0 && pending_points.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
